>>> design/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent checks in the console design.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tcw_pkg.sv
// -----------------------------------------------------------------------------
// tcw_pkg
// Screen geometry, character codes, operation codes and shared types of the
// text console writer.
// -----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int NUM_COLUMNS = 80;
  localparam int NUM_ROWS    = 25;
  localparam int CELL_COUNT  = NUM_COLUMNS * NUM_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  // Field widths
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int POS_W    = 11;
  localparam int CELL_W   = 16;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int CFG_IDX_W = 1;

  // Store sweep limits
  localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((NUM_ROWS - 1) * NUM_COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE    = ADDR_W'(NUM_COLUMNS);

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

  // Tab stops
  localparam int TAB_STOP = 8;
  localparam logic [COL_W-1:0] TAB_MASK = ~COL_W'(TAB_STOP - 1);

  // Blank cell after reset: background 1, foreground 15
  localparam logic [COLOR_W-1:0] RESET_BACK  = 4'h1;
  localparam logic [COLOR_W-1:0] RESET_FORE  = 4'hF;
  localparam logic [CELL_W-1:0]  RESET_BLANK = {RESET_BACK, RESET_FORE, CH_SPACE};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

  // Cursor update for one put request
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             wr_en;
    logic             scroll;
  } cur_upd_t;

  // Linear cell offset of a cursor position
  function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    cell_pos = POS_W'(POS_W'(row) * POS_W'(NUM_COLUMNS) + POS_W'(col));
  endfunction

endpackage

>>> design/tcw_ram.sv
// -----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module tcw_ram #(
  parameter int DEPTH  = 2000,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/tcw_cursor.sv
// -----------------------------------------------------------------------------
// tcw_cursor
// Cursor update for one put byte: control codes, printable write, column wrap
// and the scroll decision.
// -----------------------------------------------------------------------------
module tcw_cursor (
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::COL_W-1:0]  col_i,
  input  logic [tcw_pkg::ROW_W-1:0]  row_i,
  output tcw_pkg::cur_upd_t          upd_o
);
  import tcw_pkg::*;

  logic [COL_W-1:0] col_n;
  logic [ROW_W-1:0] row_n;
  logic             wr_n;
  logic             scroll_n;

  always_comb begin
    col_n    = col_i;
    row_n    = row_i;
    wr_n     = 1'b0;
    scroll_n = 1'b0;

    // Byte decode
    case (char_code_i)
      CH_BS: begin
        if (col_i != '0) begin
          col_n = col_i - COL_W'(1);
        end
      end
      CH_TAB: begin
        col_n = (col_i + COL_W'(TAB_STOP)) & TAB_MASK;
      end
      CH_LF: begin
        col_n = '0;
        row_n = row_i + ROW_W'(1);
      end
      CH_CR: begin
        col_n = '0;
      end
      default: begin
        if (char_code_i inside {[CH_SPACE:CH_TILDE]}) begin
          wr_n  = 1'b1;
          col_n = col_i + COL_W'(1);
        end
      end
    endcase

    // Wrap past the last column
    if (col_n >= COL_W'(NUM_COLUMNS)) begin
      col_n = '0;
      row_n = row_n + ROW_W'(1);
    end

    // Past the last row: scroll and hold on the bottom line
    if (row_n >= ROW_W'(NUM_ROWS)) begin
      scroll_n = 1'b1;
      row_n    = ROW_W'(NUM_ROWS - 1);
    end
  end

  assign upd_o = '{col: col_n, row: row_n, wr_en: wr_n, scroll: scroll_n};

endmodule

>>> design/text_console_char_writer.sv
// -----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console engine: screen store of character cells and a cursor.
//
// Each request carries an operation (put byte, clear screen, read cell) and
// returns one result with the cursor position and, for a read, the cell. A
// sequencer drives one cell address counter and the single write / single
// read screen RAM. A put of a printable or control byte, a read and the
// unused code pass through execute, a RAM read state for a read, and the
// result load. A put that scrolls then copies the rows up one line, as the
// RAM moves one cell a cycle, and blanks the bottom line; a clear blanks
// every cell. After reset the store is blanked in a pass during which
// requests stall; configuration writes are taken at any time. A new
// request is taken while a result still waits on the output register.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_char_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::POS_W-1:0]     cell_index_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcw_pkg::COL_W-1:0]     cursor_col_o,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row_o,
  output logic [tcw_pkg::POS_W-1:0]     cursor_position_o,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data_o
);
  import tcw_pkg::*;

  state_e               state_q, state_d;
  logic [ADDR_W-1:0]    cnt_q, cnt_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COLOR_W-1:0]   back_q, fore_q;
  op_e                  op_q;
  logic [CHAR_W-1:0]    char_q;
  logic [POS_W-1:0]     idx_q;
  logic [CELL_W-1:0]    data_q, data_d;
  logic                 out_valid_q;
  logic [COL_W-1:0]     out_col_q;
  logic [ROW_W-1:0]     out_row_q;
  logic [POS_W-1:0]     out_pos_q;
  logic [CELL_W-1:0]    out_data_q;

  logic                 in_accept;
  logic                 out_load;
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [CELL_W-1:0]    ram_wdata, ram_rdata;
  logic [CHAR_W-1:0]    attr;
  cur_upd_t             cur_upd;

  assign attr      = {back_q, fore_q};
  assign in_accept = in_valid_i && (state_q == ST_IDLE);

  // Screen store
  tcw_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (CELL_W),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Cursor update for put
  tcw_cursor u_cursor (
    .char_code_i(char_q),
    .col_i      (col_q),
    .row_i      (row_q),
    .upd_o      (cur_upd)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_q <= RESET_BACK;
      fore_q <= RESET_FORE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BACK_COLOR: back_q <= cfg_data_i;
        CFG_FORE_COLOR: fore_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // Request capture and read data
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= op_e'(operation_i);
      char_q <= char_code_i;
      idx_q  <= cell_index_i;
    end
    data_q <= data_d;
  end

  // Next state, RAM control
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    col_d     = col_q;
    row_d     = row_q;
    data_d    = data_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = {attr, CH_SPACE};
    ram_re    = 1'b0;
    ram_raddr = cnt_q;
    out_load  = 1'b0;

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = RESET_BLANK;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        data_d = '0;
        case (op_q)
          OP_PUT: begin
            ram_we    = cur_upd.wr_en;
            ram_waddr = ADDR_W'(cell_pos(row_q, col_q));
            ram_wdata = {attr, char_q};
            col_d     = cur_upd.col;
            row_d     = cur_upd.row;
            if (cur_upd.scroll) begin
              cnt_d   = '0;
              state_d = ST_SCROLL;
            end else begin
              state_d = ST_DONE;
            end
          end
          OP_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            cnt_d   = '0;
            state_d = ST_FILL;
          end
          OP_READ: begin
            if (idx_q < POS_W'(CELL_COUNT)) begin
              ram_re    = 1'b1;
              ram_raddr = ADDR_W'(idx_q);
              state_d   = ST_READ;
            end else begin
              state_d = ST_DONE;
            end
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_READ: begin
        data_d  = ram_rdata;
        state_d = ST_DONE;
      end
      ST_SCROLL: begin
        // read one row down, write the cell read in the cycle before
        ram_re    = (cnt_q < LAST_ROW_BASE);
        ram_raddr = cnt_q + ROW_STRIDE;
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (cnt_q == LAST_ROW_BASE) begin
          state_d = ST_FILL;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q  <= col_q;
      out_row_q  <= row_q;
      out_pos_q  <= cell_pos(row_q, col_q);
      out_data_q <= data_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_position_o = out_pos_q;
  assign cell_data_o       = out_data_q;

  // Checks
  `TCW_ASSERT(a_col_on_screen, col_q < COL_W'(NUM_COLUMNS), "cursor column off screen")
  `TCW_ASSERT(a_row_on_screen, row_q < ROW_W'(NUM_ROWS), "cursor row off screen")
  `TCW_ASSERT_NEXT(a_accept_exec, in_accept, state_q == ST_EXEC, "accepted request not executed")
  `TCW_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "stray result")
  `TCW_ASSERT(a_write_in_range, ram_we |-> (ram_waddr <= LAST_CELL), "store write out of range")

endmodule

>>> bench/text_console_char_writer_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// text_console_char_writer_checker
// Watches the configuration port and both request/result channels of the text
// console writer. It keeps its own copy of the screen, cursor and colours,
// works out the expected report for every accepted request and compares each
// accepted result with the oldest expected report, field by field.
// -----------------------------------------------------------------------------
module text_console_char_writer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration port
  input  logic                          cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data_i,
  // request channel
  input  logic                          req_valid_i,
  input  logic                          req_stall_i,
  input  logic [1:0]                    req_op_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    req_char_i,
  input  logic [tcw_pkg::POS_W-1:0]     req_index_i,
  // result channel
  input  logic                          res_valid_i,
  input  logic                          res_stall_i,
  input  logic [tcw_pkg::COL_W-1:0]     res_col_i,
  input  logic [tcw_pkg::ROW_W-1:0]     res_row_i,
  input  logic [tcw_pkg::POS_W-1:0]     res_pos_i,
  input  logic [tcw_pkg::CELL_W-1:0]    res_data_i,
  // status towards the bench top
  output int                            reports_due_o,
  output int                            mismatch_count_o
);
  import tcw_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] data;
  } report_t;

  // Shadow of the console state
  logic [CELL_W-1:0]  shadow_cells [CELL_COUNT];
  logic [COL_W-1:0]   shadow_col;
  logic [ROW_W-1:0]   shadow_row;
  logic [COLOR_W-1:0] shadow_back;
  logic [COLOR_W-1:0] shadow_fore;

  report_t awaited_reports [$];
  report_t want;
  report_t got;

  // Blank every cell from a given offset up to the end of the screen
  task automatic blank_from(input int first);
    for (int i = first; i < CELL_COUNT; i++) begin
      shadow_cells[i] = {shadow_back, shadow_fore, CH_SPACE};
    end
  endtask

  // Console behaviour for one request, returning the report it produces
  task automatic predict_report(input op_e op, input logic [CHAR_W-1:0] ch,
                                input logic [POS_W-1:0] idx, output report_t rep);
    logic [CELL_W-1:0] data;
    data = '0;
    case (op)
      OP_PUT: begin
        case (ch)
          CH_BS: begin
            if (shadow_col != 0) shadow_col = shadow_col - 1'b1;
          end
          CH_TAB: shadow_col = (shadow_col + COL_W'(TAB_STOP)) & TAB_MASK;
          CH_LF: begin
            shadow_col = '0;
            shadow_row = shadow_row + 1'b1;
          end
          CH_CR: shadow_col = '0;
          default: begin
            if (ch >= CH_SPACE && ch <= CH_TILDE) begin
              shadow_cells[int'(shadow_row) * NUM_COLUMNS + int'(shadow_col)] =
                {shadow_back, shadow_fore, ch};
              shadow_col = shadow_col + 1'b1;
            end
          end
        endcase
        // wrap past the last column
        if (shadow_col >= NUM_COLUMNS) begin
          shadow_col = '0;
          shadow_row = shadow_row + 1'b1;
        end
        // scroll up one line past the last row
        if (shadow_row >= NUM_ROWS) begin
          for (int i = 0; i < (NUM_ROWS - 1) * NUM_COLUMNS; i++) begin
            shadow_cells[i] = shadow_cells[i + NUM_COLUMNS];
          end
          blank_from((NUM_ROWS - 1) * NUM_COLUMNS);
          shadow_row = ROW_W'(NUM_ROWS - 1);
        end
      end
      OP_CLEAR: begin
        blank_from(0);
        shadow_col = '0;
        shadow_row = '0;
      end
      OP_READ: begin
        if (idx < CELL_COUNT) data = shadow_cells[idx];
      end
      default: ;
    endcase
    rep.col  = shadow_col;
    rep.row  = shadow_row;
    rep.pos  = POS_W'(int'(shadow_row) * NUM_COLUMNS + int'(shadow_col));
    rep.data = data;
  endtask

  // Track config, predict on each request, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_back = RESET_BACK;
      shadow_fore = RESET_FORE;
      shadow_col  = '0;
      shadow_row  = '0;
      blank_from(0);
      awaited_reports.delete();
      reports_due_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BACK_COLOR: shadow_back = cfg_data_i;
          CFG_FORE_COLOR: shadow_fore = cfg_data_i;
          default: ;
        endcase
      end

      if (res_valid_i && !res_stall_i) begin
        got = '{col: res_col_i, row: res_row_i, pos: res_pos_i, data: res_data_i};
        if (awaited_reports.size() == 0) begin
          $error("unexpected result: col %0d row %0d pos %0d data 0x%04h",
                 got.col, got.row, got.pos, got.data);
          mismatch_count_o = mismatch_count_o + 1;
        end else begin
          want = awaited_reports.pop_front();
          if (got.col !== want.col) begin
            $error("cursor_col: expected %0d, got %0d", want.col, got.col);
            mismatch_count_o = mismatch_count_o + 1;
          end
          if (got.row !== want.row) begin
            $error("cursor_row: expected %0d, got %0d", want.row, got.row);
            mismatch_count_o = mismatch_count_o + 1;
          end
          if (got.pos !== want.pos) begin
            $error("cursor_position: expected %0d, got %0d", want.pos, got.pos);
            mismatch_count_o = mismatch_count_o + 1;
          end
          if (got.data !== want.data) begin
            $error("cell_data: expected 0x%04h, got 0x%04h", want.data, got.data);
            mismatch_count_o = mismatch_count_o + 1;
          end
        end
      end

      if (req_valid_i && !req_stall_i) begin
        predict_report(op_e'(req_op_i), req_char_i, req_index_i, want);
        awaited_reports.push_back(want);
      end

      reports_due_o = awaited_reports.size();
    end
  end

  initial mismatch_count_o = 0;

endmodule

>>> bench/text_console_char_writer_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// text_console_char_writer_tb
// Bench top for the text console writer. Drives a short directed sequence of
// control bytes, printable edges, reads and a clear, then random traffic in
// several colour settings, with random gaps and stalls on both channels. The
// checker alongside the block predicts and compares every result.
// -----------------------------------------------------------------------------
module text_console_char_writer_tb;
  import tcw_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 220;
  // Bound above the slowest legal run: every request a clear or scroll plus
  // full gaps, stalls and the clearing pass after reset
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_CYCLES = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [COLOR_W-1:0]   cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [1:0]           operation_i;
  logic [CHAR_W-1:0]    char_code_i;
  logic [POS_W-1:0]     cell_index_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [COL_W-1:0]     cursor_col_o;
  logic [ROW_W-1:0]     cursor_row_o;
  logic [POS_W-1:0]     cursor_position_o;
  logic [CELL_W-1:0]    cell_data_o;

  int reports_due;
  int mismatch_count;
  int cycle_count;
  bit send_quiet;
  bit sink_quiet;

  text_console_char_writer u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .char_code_i       (char_code_i),
    .cell_index_i      (cell_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cursor_col_o      (cursor_col_o),
    .cursor_row_o      (cursor_row_o),
    .cursor_position_o (cursor_position_o),
    .cell_data_o       (cell_data_o)
  );

  text_console_char_writer_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_valid_i      (in_valid_i),
    .req_stall_i      (in_stall_o),
    .req_op_i         (operation_i),
    .req_char_i       (char_code_i),
    .req_index_i      (cell_index_i),
    .res_valid_i      (out_valid_o),
    .res_stall_i      (out_stall_i),
    .res_col_i        (cursor_col_o),
    .res_row_i        (cursor_row_o),
    .res_pos_i        (cursor_position_o),
    .res_data_i       (cell_data_o),
    .reports_due_o    (reports_due),
    .mismatch_count_o (mismatch_count)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hang guard
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle cycles before the next request or result, none in quiet stretches
  function automatic int unsigned gap_len(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(input op_e op, input logic [CHAR_W-1:0] ch,
                              input logic [POS_W-1:0] idx);
    int unsigned gap;
    gap = gap_len(send_quiet);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // Stop offering and wait for every outstanding report
  task automatic drain_reports();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (reports_due != 0) @(negedge clk_i);
  endtask

  // Byte mix leaning on printable text with plenty of control codes
  function automatic logic [CHAR_W-1:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6)       return CH_LF;
    else if (roll < 10) return CH_CR;
    else if (roll < 15) return CH_BS;
    else if (roll < 20) return CH_TAB;
    else if (roll < 28) return CHAR_W'($urandom_range(0, 255));
    else                return CHAR_W'($urandom_range(CH_SPACE, CH_TILDE));
  endfunction

  task automatic send_random();
    int unsigned       roll;
    op_e               op;
    logic [POS_W-1:0]  idx;
    roll = $urandom_range(0, 99);
    if (roll < 1)       op = OP_CLEAR;
    else if (roll < 4)  op = OP_NOP;
    else if (roll < 20) op = OP_READ;
    else                op = OP_PUT;
    if ($urandom_range(0, 19) == 0) idx = POS_W'($urandom_range(CELL_COUNT, 2047));
    else                            idx = POS_W'($urandom_range(0, CELL_COUNT - 1));
    send_request(op, pick_byte(), idx);
  endtask

  task automatic write_colors(input logic [COLOR_W-1:0] back,
                              input logic [COLOR_W-1:0] fore);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BACK_COLOR;
    cfg_data_i  <= back;
    @(negedge clk_i);
    cfg_index_i <= CFG_FORE_COLOR;
    cfg_data_i  <= fore;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int unsigned hold;
    int          taken;
    out_stall_i = 1'b0;
    sink_quiet  = 1'b0;
    taken       = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 64 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      hold = (taken == HOLD_AFTER) ? HOLD_CYCLES : gap_len(sink_quiet);
      repeat (hold) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      taken++;
    end
  end

  // Request side
  initial begin : request_source
    logic [COLOR_W-1:0] back;
    logic [COLOR_W-1:0] fore;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_BACK_COLOR;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    operation_i  = OP_NOP;
    char_code_i  = '0;
    cell_index_i = '0;
    send_quiet   = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset colours, printable edges, control codes, reads, clear
    send_request(OP_READ, 8'h00, 11'd0);
    send_request(OP_PUT, 8'h41, 11'd0);
    send_request(OP_READ, 8'hFF, 11'd0);
    send_request(OP_PUT, CH_BS, 11'd0);
    send_request(OP_PUT, CH_BS, 11'd0);        // backspace at column zero
    send_request(OP_PUT, 8'h00, 11'd0);
    send_request(OP_PUT, 8'hFF, 11'd0);
    send_request(OP_PUT, 8'h7F, 11'd0);
    send_request(OP_PUT, 8'h1F, 11'd0);
    send_request(OP_PUT, CH_SPACE, 11'd0);
    send_request(OP_PUT, CH_TILDE, 11'd0);
    send_request(OP_PUT, CH_CR, 11'd0);
    send_request(OP_PUT, CH_LF, 11'd0);
    send_request(OP_NOP, 8'hFF, 11'h7FF);
    send_request(OP_READ, 8'h00, 11'h7FF);     // beyond the screen
    send_request(OP_READ, 8'h00, 11'(CELL_COUNT));
    send_request(OP_READ, 8'h00, 11'(CELL_COUNT - 1));
    // tab stops across a whole row, the last one wraps
    repeat (NUM_COLUMNS / TAB_STOP) send_request(OP_PUT, CH_TAB, 11'd0);
    send_request(OP_CLEAR, 8'h00, 11'd0);

    // Random traffic, one colour setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_reports();
      repeat (8) @(negedge clk_i);
      case (ph)
        0: begin back = 4'h0; fore = 4'h0; end
        1: begin back = 4'hF; fore = 4'hF; end
        2: begin back = 4'h0; fore = 4'hF; end
        3: begin back = 4'hF; fore = 4'h0; end
        default: begin
          back = COLOR_W'($urandom_range(0, 15));
          fore = COLOR_W'($urandom_range(0, 15));
        end
      endcase
      write_colors(back, fore);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        // sender pause until the block has answered everything
        if (ph == 2 && i == PHASE_ITEMS / 2) drain_reports();
        send_random();
      end
    end

    drain_reports();
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_cursor.sv
design/text_console_char_writer.sv
bench/text_console_char_writer_checker.sv
bench/text_console_char_writer_tb.sv
